@@ hw/rtl/pice_pkg.sv @@
// ----------------------------------------------------------------------------
// pice_pkg: shared types, constants and tables for the point-in-element test
// Widths of the datapath, the face tables, and the microcode program.
// ----------------------------------------------------------------------------
package pice_pkg;

  // store and coordinate format
  localparam int CORNER_SLOTS = 8;
  localparam int COORD_BITS   = 24;
  localparam int SLOT_W       = 3;
  localparam int CNT_W        = 4;
  localparam int SAW          = $clog2(CORNER_SLOTS);
  localparam int MAX_FACES    = 6;
  localparam int FACE_W       = 3;
  localparam int UPC_W        = 5;

  // datapath widths
  localparam int DW   = COORD_BITS + 1;       // corner differences
  localparam int CSW  = COORD_BITS + SAW;     // corner sum, count * corner
  localparam int DCW  = CSW + 1;              // centroid offset (scaled)
  localparam int NW   = 2 * DW + 1;           // normal component
  localparam int NLO  = (NW + 1) / 2;         // low half of a normal
  localparam int NHI  = NW - NLO;             // high half of a normal
  localparam int MAW  = DCW;                  // multiplier operand a
  localparam int MBW  = NLO + 1;              // multiplier operand b
  localparam int PW   = MAW + MBW;            // product
  localparam int ACCW = DCW + NW + 2;         // accumulator

  // opcodes of an input beat
  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_TEST = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } corner_t;

  typedef enum logic [1:0] {
    SHP_TET,
    SHP_PYR,
    SHP_PRISM,
    SHP_HEX
  } shape_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // microcode fields
  typedef enum logic [2:0] {
    RD_NONE,
    RD_SUM,
    RD_X0,
    RD_X1,
    RD_X2
  } rd_sel_t;

  typedef enum logic [3:0] {
    MA_A0, MA_A1, MA_A2,
    MA_DC0, MA_DC1, MA_DC2,
    MA_DP0, MA_DP1, MA_DP2
  } ma_sel_t;

  typedef enum logic [3:0] {
    MB_B0, MB_B1, MB_B2,
    MB_LO0, MB_LO1, MB_LO2,
    MB_HI0, MB_HI1, MB_HI2
  } mb_sel_t;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    NWR_NONE,
    NWR_0,
    NWR_1,
    NWR_2
  } nrm_wr_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_BADCNT,
    C_MORE_CRN,
    C_FACE_OUT,
    C_MORE_FACES
  } cond_t;

  typedef struct packed {
    rd_sel_t           rd;
    ma_sel_t           ma;
    mb_sel_t           mb;
    acc_op_t           acc;
    logic              acc_sh;
    nrm_wr_t           nwr;
    logic              spos_wr;
    logic              idx_inc;
    logic              face_inc;
    logic              emit;
    logic              emit_val;
    cond_t             cond;
    logic [UPC_W-1:0]  target;
  } ucw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic bad_cnt;
    logic more_crn;
    logic face_out;
    logic more_faces;
  } dp_stat_t;

  // program labels
  localparam logic [UPC_W-1:0] UP_START    = 5'd0;
  localparam logic [UPC_W-1:0] UP_SUM      = 5'd1;
  localparam logic [UPC_W-1:0] UP_FACE     = 5'd2;
  localparam logic [UPC_W-1:0] UP_CROSS    = 5'd6;
  localparam logic [UPC_W-1:0] UP_DOT      = 5'd12;
  localparam logic [UPC_W-1:0] UP_TEST     = 5'd25;
  localparam logic [UPC_W-1:0] UP_NEXT     = 5'd26;
  localparam logic [UPC_W-1:0] UP_EMIT_IN  = 5'd27;
  localparam logic [UPC_W-1:0] UP_EMIT_OUT = 5'd28;

  // face corner table: first corner and the ends of both edges that leave it
  localparam logic [2:0] FACE_TABLE [4][MAX_FACES][3] = '{
    '{ '{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd3}, '{3'd2, 3'd0, 3'd3},
       '{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd0, 3'd0}, '{3'd0, 3'd0, 3'd0} },
    '{ '{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd4}, '{3'd2, 3'd3, 3'd4},
       '{3'd3, 3'd0, 3'd4}, '{3'd0, 3'd1, 3'd4}, '{3'd0, 3'd0, 3'd0} },
    '{ '{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd5}, '{3'd2, 3'd0, 3'd3},
       '{3'd3, 3'd0, 3'd4}, '{3'd3, 3'd4, 3'd5}, '{3'd0, 3'd0, 3'd0} },
    '{ '{3'd0, 3'd1, 3'd2}, '{3'd1, 3'd2, 3'd6}, '{3'd2, 3'd3, 3'd7},
       '{3'd3, 3'd0, 3'd4}, '{3'd0, 3'd1, 3'd5}, '{3'd4, 3'd5, 3'd6} }
  };

  function automatic logic [2:0] face_corner(input shape_t s,
                                             input logic [FACE_W-1:0] f,
                                             input logic [1:0] k);
    return FACE_TABLE[s][f][k];
  endfunction

  function automatic logic [FACE_W-1:0] face_count(input shape_t s);
    logic [FACE_W-1:0] n;
    unique case (s)
      SHP_TET:   n = 3'd4;
      SHP_PYR:   n = 3'd5;
      SHP_PRISM: n = 3'd5;
      SHP_HEX:   n = 3'd6;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic count_is_shape(input logic [CNT_W-1:0] c);
    return (c == 4'd4) || (c == 4'd5) || (c == 4'd6) || (c == 4'd8);
  endfunction

  function automatic shape_t shape_of(input logic [CNT_W-1:0] c);
    shape_t s;
    unique case (c)
      4'd5:    s = SHP_PYR;
      4'd6:    s = SHP_PRISM;
      4'd8:    s = SHP_HEX;
      default: s = SHP_TET;
    endcase
    return s;
  endfunction

  // microcode program, one control word per step
  function automatic ucw_t ucode(input logic [UPC_W-1:0] pc);
    ucw_t w;
    w = '0;
    unique case (pc)
      UP_START: begin
        w.cond   = C_BADCNT;
        w.target = UP_EMIT_IN;
      end
      UP_SUM: begin
        w.rd      = RD_SUM;
        w.idx_inc = 1'b1;
        w.cond    = C_MORE_CRN;
        w.target  = UP_SUM;
      end
      UP_FACE:         w.rd = RD_X0;
      UP_FACE + 5'd1:  w.rd = RD_X1;
      UP_FACE + 5'd2:  w.rd = RD_X2;
      // cross product a x b into the normal
      UP_CROSS: begin
        w.ma = MA_A1; w.mb = MB_B2;
      end
      UP_CROSS + 5'd1: begin
        w.ma = MA_A2; w.mb = MB_B1; w.acc = ACC_LOAD;
      end
      UP_CROSS + 5'd2: begin
        w.ma = MA_A2; w.mb = MB_B0; w.acc = ACC_SUB;
      end
      UP_CROSS + 5'd3: begin
        w.ma = MA_A0; w.mb = MB_B2; w.acc = ACC_LOAD; w.nwr = NWR_0;
      end
      UP_CROSS + 5'd4: begin
        w.ma = MA_A0; w.mb = MB_B1; w.acc = ACC_SUB;
      end
      UP_CROSS + 5'd5: begin
        w.ma = MA_A1; w.mb = MB_B0; w.acc = ACC_LOAD; w.nwr = NWR_1;
      end
      // centroid side dot product, normal in two halves
      UP_DOT: begin
        w.ma = MA_DC0; w.mb = MB_LO0; w.acc = ACC_SUB;
      end
      UP_DOT + 5'd1: begin
        w.ma = MA_DC0; w.mb = MB_HI0; w.acc = ACC_LOAD; w.nwr = NWR_2;
      end
      UP_DOT + 5'd2: begin
        w.ma = MA_DC1; w.mb = MB_LO1; w.acc = ACC_ADD; w.acc_sh = 1'b1;
      end
      UP_DOT + 5'd3: begin
        w.ma = MA_DC1; w.mb = MB_HI1; w.acc = ACC_ADD;
      end
      UP_DOT + 5'd4: begin
        w.ma = MA_DC2; w.mb = MB_LO2; w.acc = ACC_ADD; w.acc_sh = 1'b1;
      end
      UP_DOT + 5'd5: begin
        w.ma = MA_DC2; w.mb = MB_HI2; w.acc = ACC_ADD;
      end
      // point side dot product
      UP_DOT + 5'd6: begin
        w.ma = MA_DP0; w.mb = MB_LO0; w.acc = ACC_ADD; w.acc_sh = 1'b1;
      end
      UP_DOT + 5'd7: begin
        w.ma = MA_DP0; w.mb = MB_HI0; w.acc = ACC_LOAD; w.spos_wr = 1'b1;
      end
      UP_DOT + 5'd8: begin
        w.ma = MA_DP1; w.mb = MB_LO1; w.acc = ACC_ADD; w.acc_sh = 1'b1;
      end
      UP_DOT + 5'd9: begin
        w.ma = MA_DP1; w.mb = MB_HI1; w.acc = ACC_ADD;
      end
      UP_DOT + 5'd10: begin
        w.ma = MA_DP2; w.mb = MB_LO2; w.acc = ACC_ADD; w.acc_sh = 1'b1;
      end
      UP_DOT + 5'd11: begin
        w.ma = MA_DP2; w.mb = MB_HI2; w.acc = ACC_ADD;
      end
      UP_DOT + 5'd12: begin
        w.acc = ACC_ADD; w.acc_sh = 1'b1;
      end
      UP_TEST: begin
        w.face_inc = 1'b1;
        w.cond     = C_FACE_OUT;
        w.target   = UP_EMIT_OUT;
      end
      UP_NEXT: begin
        w.cond   = C_MORE_FACES;
        w.target = UP_FACE;
      end
      UP_EMIT_IN: begin
        w.emit = 1'b1; w.emit_val = 1'b1;
      end
      UP_EMIT_OUT: begin
        w.emit = 1'b1; w.emit_val = 1'b0;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/pice_store.sv @@
// ----------------------------------------------------------------------------
// pice_store: corner store
// One write port for corner loads, one read port with registered data.
// ----------------------------------------------------------------------------
module pice_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [pice_pkg::SAW-1:0]  waddr,
  input  pice_pkg::corner_t         wdata,
  input  logic [pice_pkg::SAW-1:0]  raddr,
  output pice_pkg::corner_t         rdata
);

  pice_pkg::corner_t mem [pice_pkg::CORNER_SLOTS];
  pice_pkg::corner_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/pice_seq.sv @@
// ----------------------------------------------------------------------------
// pice_seq: microcode sequencer
// Step counter over the program table with conditional jumps on datapath
// status; hands one control word per cycle to the datapath.
// ----------------------------------------------------------------------------
module pice_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  pice_pkg::dp_stat_t    stat,
  output pice_pkg::ucw_t        cw,
  output logic                  busy
);

  pice_pkg::seq_state_t          state_r, state_nxt;
  logic [pice_pkg::UPC_W-1:0]    upc_r, upc_nxt;
  logic                          take;

  // jump condition
  always_comb begin
    unique case (cw.cond)
      pice_pkg::C_NEVER:      take = 1'b0;
      pice_pkg::C_BADCNT:     take = stat.bad_cnt;
      pice_pkg::C_MORE_CRN:   take = stat.more_crn;
      pice_pkg::C_FACE_OUT:   take = stat.face_out;
      pice_pkg::C_MORE_FACES: take = stat.more_faces;
      default:                take = 1'b0;
    endcase
  end

  // next state and step
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    unique case (state_r)
      pice_pkg::SEQ_IDLE: begin
        upc_nxt = pice_pkg::UP_START;
        if (go) begin
          state_nxt = pice_pkg::SEQ_RUN;
        end
      end
      pice_pkg::SEQ_RUN: begin
        if (cw.emit) begin
          state_nxt = pice_pkg::SEQ_IDLE;
          upc_nxt   = pice_pkg::UP_START;
        end else if (take) begin
          upc_nxt = cw.target;
        end else begin
          upc_nxt = upc_r + 5'd1;
        end
      end
      default: begin
        state_nxt = pice_pkg::SEQ_IDLE;
        upc_nxt   = pice_pkg::UP_START;
      end
    endcase
  end

  // outputs
  always_comb begin
    unique case (state_r)
      pice_pkg::SEQ_RUN: begin
        cw   = pice_pkg::ucode(upc_r);
        busy = 1'b1;
      end
      default: begin
        cw   = '0;
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pice_pkg::SEQ_IDLE;
      upc_r   <= pice_pkg::UP_START;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
    end
  end

endmodule

@@ hw/rtl/pice_dp.sv @@
// ----------------------------------------------------------------------------
// pice_dp: datapath
// Corner sum, face edge registers, one shared multiplier with a product
// register, one accumulator, normal and sign registers, result strobe.
// ----------------------------------------------------------------------------
module pice_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  go,
  input  logic [pice_pkg::CNT_W-1:0]            cnt_in,
  input  pice_pkg::corner_t                     pt_in,
  input  pice_pkg::ucw_t                        cw,
  input  pice_pkg::corner_t                     rdata,
  output logic [pice_pkg::SAW-1:0]              raddr,
  output pice_pkg::dp_stat_t                    stat,
  output logic                                  res_valid,
  output logic                                  res_inside
);

  localparam int CB   = pice_pkg::COORD_BITS;
  localparam int DW   = pice_pkg::DW;
  localparam int CSW  = pice_pkg::CSW;
  localparam int DCW  = pice_pkg::DCW;
  localparam int NW   = pice_pkg::NW;
  localparam int NLO  = pice_pkg::NLO;
  localparam int MAW  = pice_pkg::MAW;
  localparam int MBW  = pice_pkg::MBW;
  localparam int PW   = pice_pkg::PW;
  localparam int ACCW = pice_pkg::ACCW;

  // per-test context
  logic signed [CB-1:0]               pt_r   [3];
  logic [pice_pkg::CNT_W-1:0]         cnt_r;
  pice_pkg::shape_t                   shape_r;
  logic                               bad_r;
  logic [pice_pkg::CNT_W-1:0]         idx_r;
  logic [pice_pkg::FACE_W-1:0]        face_r;
  pice_pkg::rd_sel_t                  rdk_r;

  // face operands
  logic signed [CSW-1:0]              csum_r [3];
  logic signed [CB-1:0]               x0_r   [3];
  logic signed [DW-1:0]               a_r    [3];
  logic signed [DW-1:0]               b_r    [3];
  logic signed [DCW-1:0]              dc_r   [3];
  logic signed [DW-1:0]               dp_r   [3];
  logic signed [NW-1:0]               nrm_r  [3];

  // multiply-accumulate
  logic signed [MAW-1:0]              ma_v;
  logic signed [MBW-1:0]              mb_v;
  logic signed [PW-1:0]               prod_r;
  logic signed [ACCW-1:0]             acc_r;
  logic signed [ACCW-1:0]             addend;
  logic                               spos_r;
  logic                               acc_neg, acc_pos;

  logic                               res_valid_r, res_inside_r;

  logic signed [CB-1:0]               rd_c   [3];
  logic signed [DCW-1:0]              cx0    [3];
  logic [1:0]                         fk;
  logic [2:0]                         fc_idx;

  assign rd_c[0] = rdata.x;
  assign rd_c[1] = rdata.y;
  assign rd_c[2] = rdata.z;

  // count times first corner
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cx0[k] = DCW'(rd_c[k]) * DCW'($signed({1'b0, cnt_r}));
    end
  end

  // store read address
  always_comb begin
    unique case (cw.rd)
      pice_pkg::RD_X1: fk = 2'd1;
      pice_pkg::RD_X2: fk = 2'd2;
      default:         fk = 2'd0;
    endcase
    fc_idx = pice_pkg::face_corner(shape_r, face_r, fk);
    if (cw.rd == pice_pkg::RD_SUM) begin
      raddr = idx_r[pice_pkg::SAW-1:0];
    end else begin
      raddr = fc_idx[pice_pkg::SAW-1:0];
    end
  end

  // multiplier operand a
  always_comb begin
    unique case (cw.ma)
      pice_pkg::MA_A0:  ma_v = MAW'(a_r[0]);
      pice_pkg::MA_A1:  ma_v = MAW'(a_r[1]);
      pice_pkg::MA_A2:  ma_v = MAW'(a_r[2]);
      pice_pkg::MA_DC0: ma_v = dc_r[0];
      pice_pkg::MA_DC1: ma_v = dc_r[1];
      pice_pkg::MA_DC2: ma_v = dc_r[2];
      pice_pkg::MA_DP0: ma_v = MAW'(dp_r[0]);
      pice_pkg::MA_DP1: ma_v = MAW'(dp_r[1]);
      pice_pkg::MA_DP2: ma_v = MAW'(dp_r[2]);
      default:          ma_v = '0;
    endcase
  end

  // multiplier operand b: edge, or low / high half of a normal
  always_comb begin
    unique case (cw.mb)
      pice_pkg::MB_B0:  mb_v = MBW'(b_r[0]);
      pice_pkg::MB_B1:  mb_v = MBW'(b_r[1]);
      pice_pkg::MB_B2:  mb_v = MBW'(b_r[2]);
      pice_pkg::MB_LO0: mb_v = $signed({1'b0, nrm_r[0][NLO-1:0]});
      pice_pkg::MB_LO1: mb_v = $signed({1'b0, nrm_r[1][NLO-1:0]});
      pice_pkg::MB_LO2: mb_v = $signed({1'b0, nrm_r[2][NLO-1:0]});
      pice_pkg::MB_HI0: mb_v = MBW'($signed(nrm_r[0][NW-1:NLO]));
      pice_pkg::MB_HI1: mb_v = MBW'($signed(nrm_r[1][NW-1:NLO]));
      pice_pkg::MB_HI2: mb_v = MBW'($signed(nrm_r[2][NW-1:NLO]));
      default:          mb_v = '0;
    endcase
  end

  // product aligned for the accumulator
  assign addend = cw.acc_sh ? (ACCW'(prod_r) <<< NLO) : ACCW'(prod_r);

  assign acc_neg = acc_r[ACCW-1];
  assign acc_pos = !acc_r[ACCW-1] && (acc_r != '0);

  // status to the sequencer
  always_comb begin
    stat.bad_cnt    = bad_r;
    stat.more_crn   = (idx_r != (cnt_r - 4'd1));
    stat.face_out   = spos_r ? acc_neg : acc_pos;
    stat.more_faces = (face_r != pice_pkg::face_count(shape_r));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      face_r      <= '0;
      rdk_r       <= pice_pkg::RD_NONE;
      res_valid_r <= 1'b0;
    end else begin
      rdk_r       <= cw.rd;
      res_valid_r <= cw.emit;
      if (go) begin
        idx_r  <= '0;
        face_r <= '0;
      end else begin
        if (cw.idx_inc) begin
          idx_r <= idx_r + 4'd1;
        end
        if (cw.face_inc) begin
          face_r <= face_r + 3'd1;
        end
      end
    end
  end

  // test context latched at accept
  always_ff @(posedge clk) begin
    if (go) begin
      pt_r[0] <= pt_in.x;
      pt_r[1] <= pt_in.y;
      pt_r[2] <= pt_in.z;
      cnt_r   <= cnt_in;
      shape_r <= pice_pkg::shape_of(cnt_in);
      bad_r   <= !pice_pkg::count_is_shape(cnt_in) ||
                 (int'(cnt_in) > pice_pkg::CORNER_SLOTS);
    end
  end

  // corner sum and face operands from store read data
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (go) begin
        csum_r[k] <= '0;
      end else if (rdk_r == pice_pkg::RD_SUM) begin
        csum_r[k] <= csum_r[k] + CSW'(rd_c[k]);
      end
      if (rdk_r == pice_pkg::RD_X0) begin
        x0_r[k] <= rd_c[k];
        dp_r[k] <= DW'(pt_r[k]) - DW'(rd_c[k]);
        dc_r[k] <= DCW'(csum_r[k]) - cx0[k];
      end
      if (rdk_r == pice_pkg::RD_X1) begin
        a_r[k] <= DW'(rd_c[k]) - DW'(x0_r[k]);
      end
      if (rdk_r == pice_pkg::RD_X2) begin
        b_r[k] <= DW'(rd_c[k]) - DW'(x0_r[k]);
      end
    end
  end

  // multiplier, accumulator, normal and sign registers
  always_ff @(posedge clk) begin
    prod_r <= ma_v * mb_v;
    unique case (cw.acc)
      pice_pkg::ACC_LOAD: acc_r <= addend;
      pice_pkg::ACC_ADD:  acc_r <= acc_r + addend;
      pice_pkg::ACC_SUB:  acc_r <= acc_r - addend;
      default:            acc_r <= acc_r;
    endcase
    unique case (cw.nwr)
      pice_pkg::NWR_0: nrm_r[0] <= acc_r[NW-1:0];
      pice_pkg::NWR_1: nrm_r[1] <= acc_r[NW-1:0];
      pice_pkg::NWR_2: nrm_r[2] <= acc_r[NW-1:0];
      default: ;
    endcase
    if (cw.spos_wr) begin
      spos_r <= acc_pos;
    end
    if (cw.emit) begin
      res_inside_r <= cw.emit_val;
    end
  end

  assign res_valid  = res_valid_r;
  assign res_inside = res_inside_r;

endmodule

@@ hw/rtl/point_in_convex_element_test.sv @@
// ----------------------------------------------------------------------------
// point_in_convex_element_test: point against convex 3D element
// Loads element corners into slots and tests points against the faces of a
// tetrahedron, pyramid, prism or hexahedron with exact integer signs.
// ----------------------------------------------------------------------------
// A load never raises busy.
// A test sums the corners, then works through the faces one at a time on the
// one shared multiplier, stopping early when a face rejects and at once for
// an unsupported count; the result strobe follows in the cycle after the
// emit step. The next beat is taken in the strobe cycle.
// Reset clears the sequencer and the strobe; the corner store is not cleared.
module point_in_convex_element_test (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_opcode,
  input  logic [pice_pkg::SLOT_W-1:0]            in_slot,
  input  logic [pice_pkg::CNT_W-1:0]             in_corner_count,
  input  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_z,
  output logic                                   out_valid,
  output logic                                   out_inside_res
);

  logic                          accept;
  logic                          load_we;
  logic                          test_go;
  pice_pkg::corner_t             in_corner;
  pice_pkg::corner_t             rdata;
  logic [pice_pkg::SAW-1:0]      raddr;
  pice_pkg::ucw_t                cw;
  pice_pkg::dp_stat_t            stat;

  // input beat decode
  assign accept  = start && !busy;
  assign load_we = accept && (in_opcode == pice_pkg::OPC_LOAD) &&
                   (int'(in_slot) < pice_pkg::CORNER_SLOTS);
  assign test_go = accept && (in_opcode == pice_pkg::OPC_TEST);

  assign in_corner.x = in_coord_x;
  assign in_corner.y = in_coord_y;
  assign in_corner.z = in_coord_z;

  pice_store u_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_slot[pice_pkg::SAW-1:0]),
    .wdata (in_corner),
    .raddr (raddr),
    .rdata (rdata)
  );

  pice_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (test_go),
    .stat  (stat),
    .cw    (cw),
    .busy  (busy)
  );

  pice_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (test_go),
    .cnt_in     (in_corner_count),
    .pt_in      (in_corner),
    .cw         (cw),
    .rdata      (rdata),
    .raddr      (raddr),
    .stat       (stat),
    .res_valid  (out_valid),
    .res_inside (out_inside_res)
  );

  // a load beat never starts the sequencer
  a_load_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == pice_pkg::OPC_LOAD) |=> !busy)
    else $error("load beat started the sequencer");

  // a test beat always starts the sequencer
  a_test_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == pice_pkg::OPC_TEST) |=> busy)
    else $error("test beat did not start the sequencer");

  // a result beat closes a run
  a_strobe_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a run");

endmodule

@@ test/element_test_checker.sv @@
// ----------------------------------------------------------------------------
// element_test_checker: verdict predictor and scoreboard for the element test
// Keeps its own copy of the corner store from accepted load beats, works out
// the inside/outside verdict of each accepted test beat with exact wide
// integers, and compares every result strobe with the oldest waiting verdict.
// ----------------------------------------------------------------------------
module element_test_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic                                   in_opcode,
  input  logic [pice_pkg::SLOT_W-1:0]            in_slot,
  input  logic [pice_pkg::CNT_W-1:0]             in_corner_count,
  input  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_z,
  input  logic                                   out_valid,
  input  logic                                   out_inside_res,
  output int unsigned                            fail_count,
  output int unsigned                            pending_count
);

  // corner counts that select a face table
  localparam logic [3:0] CNT_TET   = 4'd4;
  localparam logic [3:0] CNT_PYR   = 4'd5;
  localparam logic [3:0] CNT_PRISM = 4'd6;
  localparam logic [3:0] CNT_HEX   = 4'd8;

  // face lists, face 0 in the low bits, one octal digit per corner:
  // first corner and the ends of both edges that leave it
  localparam logic [53:0] TET_FACES   = 54'o000_000_013_203_123_012;
  localparam logic [53:0] PYR_FACES   = 54'o000_014_304_234_124_012;
  localparam logic [53:0] PRISM_FACES = 54'o000_345_304_203_125_012;
  localparam logic [53:0] HEX_FACES   = 54'o456_015_304_237_126_012;

  // wide enough that no product or sum can wrap
  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic        in_elem;
    logic [31:0] tag;
  } verdict_t;

  wide_t       crn_x [pice_pkg::CORNER_SLOTS];
  wide_t       crn_y [pice_pkg::CORNER_SLOTS];
  wide_t       crn_z [pice_pkg::CORNER_SLOTS];
  verdict_t    verdict_q [$];
  int unsigned mismatches = 0;
  int unsigned tests_seen = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < 100)
      $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // one face: true when the point lies strictly beyond it
  function automatic bit face_outside(input logic [8:0] fc, input wide_t n_w,
                                      input wide_t sx, input wide_t sy,
                                      input wide_t sz, input wide_t px,
                                      input wide_t py, input wide_t pz);
    logic [2:0] i0, i1, i2;
    wide_t      ax, ay, az, bx, by, bz, nx, ny, nz, side_c, side_p;
    i0 = fc[8:6];
    i1 = fc[5:3];
    i2 = fc[2:0];
    ax = crn_x[i1] - crn_x[i0];
    ay = crn_y[i1] - crn_y[i0];
    az = crn_z[i1] - crn_z[i0];
    bx = crn_x[i2] - crn_x[i0];
    by = crn_y[i2] - crn_y[i0];
    bz = crn_z[i2] - crn_z[i0];
    nx = ay * bz - az * by;
    ny = az * bx - ax * bz;
    nz = ax * by - ay * bx;
    // centroid kept as the corner sum, so compare against count * corner
    side_c = (sx - n_w * crn_x[i0]) * nx + (sy - n_w * crn_y[i0]) * ny
           + (sz - n_w * crn_z[i0]) * nz;
    side_p = (px - crn_x[i0]) * nx + (py - crn_y[i0]) * ny
           + (pz - crn_z[i0]) * nz;
    // normal toward the centroid is flipped; a zero normal never rejects
    return (side_c > 0) ? (side_p < 0) : (side_p > 0);
  endfunction

  // verdict of a test beat against the current corner store
  function automatic bit point_inside(input logic [3:0] n, input wide_t px,
                                      input wide_t py, input wide_t pz);
    logic [53:0] faces;
    int          n_faces, i;
    wide_t       sx, sy, sz, n_w;
    case (n)
      CNT_TET: begin
        faces = TET_FACES; n_faces = 4;
      end
      CNT_PYR: begin
        faces = PYR_FACES; n_faces = 5;
      end
      CNT_PRISM: begin
        faces = PRISM_FACES; n_faces = 5;
      end
      CNT_HEX: begin
        faces = HEX_FACES; n_faces = 6;
      end
      default: return 1'b1;
    endcase
    n_w = wide_t'(n);
    sx = 0;
    sy = 0;
    sz = 0;
    for (i = 0; i < n; i++) begin
      sx += crn_x[i];
      sy += crn_y[i];
      sz += crn_z[i];
    end
    for (i = 0; i < n_faces; i++)
      if (face_outside(faces[i*9 +: 9], n_w, sx, sy, sz, px, py, pz))
        return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst_n) begin
      // result strobe against the oldest waiting verdict
      if (out_valid !== 1'b0) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result %0b with no test waiting",
                                    out_inside_res));
        end else begin
          want = verdict_q.pop_front();
          if (out_inside_res !== want.in_elem)
            report_mismatch($sformatf("test %0d: inside_res %0b, want %0b",
                                      want.tag, out_inside_res, want.in_elem));
        end
      end
      // accepted input beat
      if (start && !busy) begin
        if (in_opcode == pice_pkg::OPC_LOAD) begin
          crn_x[in_slot] = wide_t'(in_coord_x);
          crn_y[in_slot] = wide_t'(in_coord_y);
          crn_z[in_slot] = wide_t'(in_coord_z);
        end else begin
          want.in_elem = point_inside(in_corner_count, wide_t'(in_coord_x),
                                      wide_t'(in_coord_y), wide_t'(in_coord_z));
          want.tag = tests_seen;
          tests_seen++;
          verdict_q.push_back(want);
        end
      end
    end
    pending_count <= verdict_q.size();
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the point-in-element test block
// Loads tetrahedra, pyramids, prisms and hexahedra built on random bounding
// boxes, tests points inside, outside and on them under varying sender idle,
// and leaves prediction and checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CMIN         = -(1 << (pice_pkg::COORD_BITS - 1));
  localparam int CMAX         = (1 << (pice_pkg::COORD_BITS - 1)) - 1;
  localparam int N_ITEMS      = 1500;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [3:0] CNT_TET   = 4'd4;
  localparam logic [3:0] CNT_PYR   = 4'd5;
  localparam logic [3:0] CNT_PRISM = 4'd6;
  localparam logic [3:0] CNT_HEX   = 4'd8;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   start;
  logic                                   busy;
  logic                                   in_opcode;
  logic [pice_pkg::SLOT_W-1:0]            in_slot;
  logic [pice_pkg::CNT_W-1:0]             in_corner_count;
  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_x;
  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_y;
  logic signed [pice_pkg::COORD_BITS-1:0] in_coord_z;
  logic                                   out_valid;
  logic                                   out_inside_res;
  int unsigned                            fail_count;
  int unsigned                            pending_count;

  int       bound_lo [3];
  int       bound_hi [3];
  logic [7:0] loaded;
  int       n_items;
  int       idle_pct;

  point_in_convex_element_test u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_slot         (in_slot),
    .in_corner_count (in_corner_count),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res)
  );

  element_test_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_slot         (in_slot),
    .in_corner_count (in_corner_count),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int clamp_coord(input longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return int'(v);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << pice_pkg::COORD_BITS) - 1)) + CMIN;
  endfunction

  // bounding box of the next element, per axis
  task automatic pick_bounds();
    int     a;
    longint c, e;
    for (a = 0; a < 3; a++) begin
      case ($urandom_range(0, 19))
        0: begin
          bound_lo[a] = CMIN;
          bound_hi[a] = CMAX;
        end
        1: begin
          // flat along this axis: degenerate faces
          bound_lo[a] = rand_coord();
          bound_hi[a] = bound_lo[a];
        end
        default: begin
          c = rand_coord();
          e = $urandom_range(0, 1 << $urandom_range(4, 22));
          bound_lo[a] = clamp_coord(c - e);
          bound_hi[a] = clamp_coord(c + e);
        end
      endcase
    end
  endtask

  // one coordinate of a test point near the current box
  function automatic int point_coord(input int a);
    longint span, v;
    span = longint'(bound_hi[a]) - bound_lo[a];
    case ($urandom_range(0, 9))
      0: v = bound_lo[a];
      1: v = bound_hi[a];
      2: v = rand_coord();
      3: v = ($urandom_range(0, 1) == 0) ? CMIN : CMAX;
      default: v = bound_lo[a] - span / 4
                 + longint'($urandom_range(0, span + span / 2));
    endcase
    return clamp_coord(v);
  endfunction

  // drive one beat, hold it until taken, then maybe idle
  task automatic issue(input logic op, input logic [2:0] slot,
                       input logic [3:0] cnt, input int x, input int y,
                       input int z);
    start           <= 1'b1;
    in_opcode       <= op;
    in_slot         <= slot;
    in_corner_count <= cnt;
    in_coord_x      <= x[pice_pkg::COORD_BITS-1:0];
    in_coord_y      <= y[pice_pkg::COORD_BITS-1:0];
    in_coord_z      <= z[pice_pkg::COORD_BITS-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == pice_pkg::OPC_LOAD) loaded[slot] = 1'b1;
    n_items++;
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      // mostly short gaps, some long enough to span a whole test
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(5, 120)
                                          : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // load the corners of one element into slots 0 .. n_crn-1
  task automatic load_element(input logic [3:0] n_crn, input bit jitter,
                              input bit noise);
    int i, a;
    int c [3];
    bit up [3];
    for (i = 0; i < n_crn; i++) begin
      // corner on the box in the shape's corner numbering
      case (n_crn)
        CNT_TET: begin
          up[0] = (i == 1); up[1] = (i == 2); up[2] = (i == 3);
        end
        CNT_PRISM: begin
          up[0] = (i % 3 == 1); up[1] = (i % 3 == 2); up[2] = (i >= 3);
        end
        default: begin
          up[0] = ((i + 1) & 2) != 0; up[1] = (i & 2) != 0; up[2] = (i >= 4);
        end
      endcase
      for (a = 0; a < 3; a++)
        c[a] = up[a] ? bound_hi[a] : bound_lo[a];
      // pyramid apex over the middle of the base
      if (n_crn == CNT_PYR && i == 4) begin
        c[0] = (bound_lo[0] + bound_hi[0]) >>> 1;
        c[1] = (bound_lo[1] + bound_hi[1]) >>> 1;
        c[2] = bound_hi[2];
      end
      for (a = 0; a < 3; a++) begin
        if (jitter) c[a] = clamp_coord(longint'(c[a]) + int'($urandom_range(0, 64)) - 32);
        if (noise) c[a] = rand_coord();
      end
      issue(pice_pkg::OPC_LOAD, 3'(i), 4'($urandom_range(0, 15)), c[0], c[1], c[2]);
    end
  endtask

  // count of a test beat: mostly the element's own
  function automatic logic [3:0] pick_count(input logic [3:0] elem_cnt);
    logic [3:0] c;
    int         m;
    case ($urandom_range(0, 9))
      0: begin
        // another shape over the loaded slots
        case ($urandom_range(0, 3))
          0: c = CNT_TET;
          1: c = CNT_PYR;
          2: c = CNT_PRISM;
          default: c = CNT_HEX;
        endcase
        m = (1 << c) - 1;
        if ((int'(loaded) & m) != m) c = elem_cnt;
      end
      1: begin
        // count with no face table
        c = 4'($urandom_range(0, 15));
        while (c == CNT_TET || c == CNT_PYR || c == CNT_PRISM || c == CNT_HEX)
          c = 4'($urandom_range(0, 15));
      end
      default: c = elem_cnt;
    endcase
    return c;
  endfunction

  initial begin : stimulus
    int         k, n_tests;
    logic [3:0] elem_cnt;
    start           <= 1'b0;
    rst_n           <= 1'b0;
    in_opcode       <= pice_pkg::OPC_LOAD;
    in_slot         <= '0;
    in_corner_count <= '0;
    in_coord_x      <= '0;
    in_coord_y      <= '0;
    in_coord_z      <= '0;
    loaded   = '0;
    n_items  = 0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // counts with no face table: no corner is read
    issue(pice_pkg::OPC_TEST, 3'd0, 4'd0, CMIN, CMIN, CMIN);
    issue(pice_pkg::OPC_TEST, 3'd7, 4'd15, CMAX, CMAX, CMAX);
    issue(pice_pkg::OPC_TEST, 3'd5, 4'd7, 0, 0, 0);
    issue(pice_pkg::OPC_TEST, 3'd2, 4'd3, -1, 1, -1);

    // hexahedron spanning the full coordinate range
    for (k = 0; k < 3; k++) begin
      bound_lo[k] = CMIN;
      bound_hi[k] = CMAX;
    end
    load_element(CNT_HEX, 1'b0, 1'b0);
    issue(pice_pkg::OPC_TEST, 3'd1, CNT_HEX, 0, 0, 0);
    issue(pice_pkg::OPC_TEST, 3'd6, CNT_PYR, CMAX, CMAX, CMAX);
    issue(pice_pkg::OPC_TEST, 3'd3, CNT_PRISM, CMIN, CMAX, CMIN);

    // degenerate tetrahedron: all four corners at one point
    for (k = 0; k < 4; k++)
      issue(pice_pkg::OPC_LOAD, 3'(k), 4'd0, 4096, -4096, 4096);
    issue(pice_pkg::OPC_TEST, 3'd4, CNT_TET, CMAX, CMIN, 0);
    issue(pice_pkg::OPC_TEST, 3'd0, CNT_HEX, 4096, -4096, 4096);

    // random elements, each followed by a run of test points
    while (n_items < N_ITEMS) begin
      idle_pct = (n_items < 500) ? 0 : (n_items < 1000) ? 70 : 37;
      pick_bounds();
      if ($urandom_range(0, 3) == 0)
        issue(pice_pkg::OPC_LOAD, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
              rand_coord(), rand_coord(), rand_coord());
      case ($urandom_range(0, 3))
        0: elem_cnt = CNT_TET;
        1: elem_cnt = CNT_PYR;
        2: elem_cnt = CNT_PRISM;
        default: elem_cnt = CNT_HEX;
      endcase
      load_element(elem_cnt, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      n_tests = $urandom_range(1, 8);
      for (k = 0; k < n_tests; k++)
        issue(pice_pkg::OPC_TEST, 3'($urandom_range(0, 7)), pick_count(elem_cnt),
              point_coord(0), point_coord(1), point_coord(2));
    end
    start <= 1'b0;

    // drain the remaining verdicts, then watch for stray strobes
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
